FILE: rtl/cdad_pkg.sv
// shared types, constants and calendar helper functions for the date adder
package cdad_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int AMT_W   = 18;
    localparam int YOE_W   = 9;
    localparam int PC_W    = 4;
    localparam int KIDX_W  = 3;

    localparam logic [YEAR_W-1:0] MAX_YEAR = 14'd9999;
    localparam logic [AMT_W-1:0]  ERA_DAYS = 18'd146097;

    typedef logic [PC_W-1:0] t_pc;

    // microprogram addresses
    localparam t_pc PC_WAIT  = 4'd0;
    localparam t_pc PC_RED0  = 4'd1;
    localparam t_pc PC_RED1  = 4'd2;
    localparam t_pc PC_RED2  = 4'd3;
    localparam t_pc PC_RED3  = 4'd4;
    localparam t_pc PC_RED4  = 4'd5;
    localparam t_pc PC_RED5  = 4'd6;
    localparam t_pc PC_SETUP = 4'd7;
    localparam t_pc PC_ERA   = 4'd8;
    localparam t_pc PC_ALIGN = 4'd9;
    localparam t_pc PC_QUAD  = 4'd10;
    localparam t_pc PC_YEAR  = 4'd11;
    localparam t_pc PC_MONTH = 4'd12;
    localparam t_pc PC_EMIT  = 4'd13;

    typedef enum logic [2:0] {
        UOP_WAIT,
        UOP_RED,
        UOP_SETUP,
        UOP_LOOP,
        UOP_EMIT
    } t_uop;

    typedef enum logic [1:0] {
        AMT_ERA,
        AMT_QUAD,
        AMT_YEAR,
        AMT_MONTH
    } t_amt;

    typedef struct packed {
        t_uop              op;
        t_amt              amt;
        logic [KIDX_W-1:0] kidx;
        logic              chk_ovf;
        logic              chk_align;
        t_pc               jmp;
    } t_uword;

    // leap rule on the year within its 400-year era
    function automatic logic f_leap(input logic [YOE_W-1:0] yoe);
        logic century;
        century = (yoe == 9'd100) || (yoe == 9'd200) || (yoe == 9'd300);
        return (yoe[1:0] == 2'b00) && !century;
    endfunction

    function automatic logic [DAY_W-1:0] f_month_len(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // days in the year before the first of month m
    function automatic logic [8:0] f_cum(input logic [MONTH_W-1:0] m, input logic leap);
        logic [8:0] c;
        case (m)
            4'd1:    c = 9'd0;
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c + 9'((leap && (m > 4'd2)) ? 1 : 0);
    endfunction

    // shifted multiples of 400 for the restoring year-of-era reduction
    function automatic logic [YEAR_W-1:0] f_red_k(input logic [KIDX_W-1:0] idx);
        logic [YEAR_W-1:0] k;
        case (idx)
            3'd0:    k = 14'd12800;
            3'd1:    k = 14'd6400;
            3'd2:    k = 14'd3200;
            3'd3:    k = 14'd1600;
            3'd4:    k = 14'd800;
            3'd5:    k = 14'd400;
            default: k = 14'd0;
        endcase
        return k;
    endfunction

endpackage

FILE: rtl/calendar_date_add_days.sv
// top level: gregorian date plus days, run by a microcoded sequencer
// steps: six year reductions, setup, loops over 400-year eras, 4-year blocks, single
//   years (at most 6) and months, then emit; blocks and years are skipped if the days
//   run out before a multiple-of-four year, all loops for a start year past 9999
// throughput: one request at a time, the next is taken once the result is parked
// reset: synchronous active-low, clears the step counter and the output valid
module calendar_date_add_days #(
    parameter int DAYS_WIDTH = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [cdad_pkg::YEAR_W-1:0]     i_start_year,
    input  logic [cdad_pkg::MONTH_W-1:0]    i_start_month,
    input  logic [cdad_pkg::DAY_W-1:0]      i_start_day,
    input  logic [DAYS_WIDTH-1:0]           i_days_to_add,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [cdad_pkg::YEAR_W-1:0]     o_end_year,
    output logic [cdad_pkg::MONTH_W-1:0]    o_end_month,
    output logic [cdad_pkg::DAY_W-1:0]      o_end_day,
    output logic                            o_year_overflow
);
    import cdad_pkg::*;

    localparam int NW = DAYS_WIDTH + 1;
    localparam int CW = (NW > AMT_W) ? NW : AMT_W;

    t_pc                r_pc, n_pc;
    logic [YEAR_W-1:0]  r_y, n_y;
    logic [YEAR_W-1:0]  r_yoe, n_yoe;
    logic [MONTH_W-1:0] r_m, n_m;
    logic [DAY_W-1:0]   r_d, n_d;
    logic [NW-1:0]      r_n, n_n;
    logic               r_o_valid, n_o_valid;
    logic [YEAR_W-1:0]  r_o_year, n_o_year;
    logic [MONTH_W-1:0] r_o_month, n_o_month;
    logic [DAY_W-1:0]   r_o_day, n_o_day;
    logic               r_o_ovf, n_o_ovf;

    t_uword             uw;
    logic               leap;
    logic               ovf;
    logic [DAY_W-1:0]   mlen;
    logic [DAY_W-1:0]   dcl;
    logic [8:0]         doy;
    logic [AMT_W-1:0]   amt_val;
    logic [CW-1:0]      n_cmp;
    logic [CW-1:0]      a_cmp;
    logic               take;
    logic [YEAR_W-1:0]  red_k;
    logic [YEAR_W-1:0]  y_inc;
    logic [YOE_W:0]     yoe_sum;
    logic [MONTH_W-1:0] m_in;

    cdad_ucode u_ucode (
        .i_pc   (r_pc),
        .o_word (uw)
    );

    // calendar facts of the current year and month
    always_comb begin
        leap  = f_leap(r_yoe[YOE_W-1:0]);
        ovf   = r_y > MAX_YEAR;
        mlen  = f_month_len(r_m, leap);
        dcl   = (r_d == '0) ? 5'd1 : ((r_d > mlen) ? mlen : r_d);
        doy   = f_cum(r_m, leap) + 9'(dcl) - 9'd1;
        red_k = f_red_k(uw.kidx);
        m_in  = (i_start_month == 4'd0) ? 4'd1 :
                ((i_start_month > 4'd12) ? 4'd12 : i_start_month);
    end

    // amount of days a loop step removes, and what it adds to the year
    always_comb begin
        case (uw.amt)
            AMT_ERA: begin
                amt_val = ERA_DAYS;
                y_inc   = 14'd400;
            end
            AMT_QUAD: begin
                amt_val = 18'd1460 + 18'(leap);
                y_inc   = 14'd4;
            end
            AMT_YEAR: begin
                amt_val = 18'd365 + 18'(leap);
                y_inc   = 14'd1;
            end
            AMT_MONTH: begin
                amt_val = 18'(mlen);
                y_inc   = 14'd0;
            end
            default: begin
                amt_val = ERA_DAYS;
                y_inc   = 14'd0;
            end
        endcase
        n_cmp   = CW'(r_n);
        a_cmp   = CW'(amt_val);
        take    = n_cmp >= a_cmp;
        yoe_sum = {1'b0, r_yoe[YOE_W-1:0]} + (YOE_W+1)'(y_inc);
    end

    // sequencer and datapath next state
    always_comb begin
        n_pc      = r_pc;
        n_y       = r_y;
        n_yoe     = r_yoe;
        n_m       = r_m;
        n_d       = r_d;
        n_n       = r_n;
        n_o_valid = r_o_valid;
        n_o_year  = r_o_year;
        n_o_month = r_o_month;
        n_o_day   = r_o_day;
        n_o_ovf   = r_o_ovf;
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end
        case (uw.op)
            // take a request
            UOP_WAIT: begin
                if (i_valid) begin
                    n_y   = i_start_year;
                    n_yoe = i_start_year;
                    n_m   = m_in;
                    n_d   = i_start_day;
                    n_n   = NW'(i_days_to_add);
                    n_pc  = uw.jmp;
                end
            end
            // year modulo 400 by restoring subtraction
            UOP_RED: begin
                if (r_yoe >= red_k) begin
                    n_yoe = r_yoe - red_k;
                end
                n_pc = r_pc + 4'd1;
            end
            // day count from the first of january of the start year
            UOP_SETUP: begin
                n_n = r_n + NW'(doy);
                n_m = 4'd1;
                n_pc = ovf ? uw.jmp : r_pc + 4'd1;
            end
            // subtract while the amount fits
            UOP_LOOP: begin
                if (uw.chk_ovf && ovf) begin
                    n_pc = PC_EMIT;
                end else if (uw.chk_align && (r_yoe[1:0] == 2'b00)) begin
                    n_pc = r_pc + 4'd1;
                end else if (take) begin
                    n_n = NW'(n_cmp - a_cmp);
                    if (uw.amt == AMT_MONTH) begin
                        n_m = r_m + 4'd1;
                    end else begin
                        n_y = r_y + y_inc;
                        if (uw.amt != AMT_ERA) begin
                            n_yoe = (yoe_sum >= 10'd400) ?
                                    YEAR_W'(yoe_sum - 10'd400) : YEAR_W'(yoe_sum);
                        end
                    end
                end else begin
                    n_pc = uw.jmp;
                end
            end
            // park the result once the output register is free
            UOP_EMIT: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_ovf   = ovf;
                    n_o_year  = ovf ? '0 : r_y;
                    n_o_month = ovf ? '0 : r_m;
                    n_o_day   = ovf ? '0 : DAY_W'(r_n + NW'(1));
                    n_pc      = uw.jmp;
                end
            end
            default: n_pc = PC_WAIT;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= PC_WAIT;
            r_o_valid <= 1'b0;
        end else begin
            r_pc      <= n_pc;
            r_o_valid <= n_o_valid;
        end
    end

    // datapath and output registers
    always_ff @(posedge i_clk) begin
        r_y       <= n_y;
        r_yoe     <= n_yoe;
        r_m       <= n_m;
        r_d       <= n_d;
        r_n       <= n_n;
        r_o_year  <= n_o_year;
        r_o_month <= n_o_month;
        r_o_day   <= n_o_day;
        r_o_ovf   <= n_o_ovf;
    end

    assign o_ready         = (uw.op == UOP_WAIT);
    assign o_valid         = r_o_valid;
    assign o_end_year      = r_o_year;
    assign o_end_month     = r_o_month;
    assign o_end_day       = r_o_day;
    assign o_year_overflow = r_o_ovf;

endmodule

FILE: rtl/cdad_ucode.sv
// microcode rom: one control word per sequencer step
module cdad_ucode (
    input  cdad_pkg::t_pc    i_pc,
    output cdad_pkg::t_uword o_word
);
    import cdad_pkg::*;

    // program listing
    always_comb begin
        o_word = '{op: UOP_WAIT, amt: AMT_ERA, kidx: 3'd0, chk_ovf: 1'b0,
                   chk_align: 1'b0, jmp: PC_WAIT};
        case (i_pc)
            PC_WAIT:  o_word.jmp = PC_RED0;
            PC_RED0: begin
                o_word.op = UOP_RED; o_word.kidx = 3'd0;
            end
            PC_RED1: begin
                o_word.op = UOP_RED; o_word.kidx = 3'd1;
            end
            PC_RED2: begin
                o_word.op = UOP_RED; o_word.kidx = 3'd2;
            end
            PC_RED3: begin
                o_word.op = UOP_RED; o_word.kidx = 3'd3;
            end
            PC_RED4: begin
                o_word.op = UOP_RED; o_word.kidx = 3'd4;
            end
            PC_RED5: begin
                o_word.op = UOP_RED; o_word.kidx = 3'd5;
            end
            PC_SETUP: begin
                o_word.op = UOP_SETUP; o_word.jmp = PC_EMIT;
            end
            // whole eras while the year is still in range
            PC_ERA: begin
                o_word.op = UOP_LOOP; o_word.amt = AMT_ERA;
                o_word.chk_ovf = 1'b1; o_word.jmp = PC_ALIGN;
            end
            // single years up to a multiple of four, leaving early if the days run out
            PC_ALIGN: begin
                o_word.op = UOP_LOOP; o_word.amt = AMT_YEAR;
                o_word.chk_align = 1'b1; o_word.jmp = PC_MONTH;
            end
            PC_QUAD: begin
                o_word.op = UOP_LOOP; o_word.amt = AMT_QUAD; o_word.jmp = PC_YEAR;
            end
            PC_YEAR: begin
                o_word.op = UOP_LOOP; o_word.amt = AMT_YEAR; o_word.jmp = PC_MONTH;
            end
            PC_MONTH: begin
                o_word.op = UOP_LOOP; o_word.amt = AMT_MONTH; o_word.jmp = PC_EMIT;
            end
            PC_EMIT: begin
                o_word.op = UOP_EMIT; o_word.jmp = PC_WAIT;
            end
            default: o_word.jmp = PC_WAIT;
        endcase
    end

endmodule
